/* hw/rtl/dws_pkg.sv */
`default_nettype none

package dws_pkg;

   // Default sizes
   localparam int unsigned DWS_MAX_WINDOW = 32;
   localparam int unsigned DWS_MAX_LINE   = 16384;

   // Field widths
   localparam int unsigned DWS_PIXEL_W   = 8;
   localparam int unsigned DWS_LEN_W     = 6;
   localparam int unsigned DWS_GAIN_W    = 16;
   localparam int unsigned DWS_CSR_IDX_W = 1;
   localparam int unsigned DWS_CSR_DAT_W = 16;

   // Quotient bits of the final divide
   localparam int unsigned DWS_QUO_W = 8;

   localparam logic [DWS_PIXEL_W-1:0] DWS_PIXEL_MAX  = 8'd255;
   localparam logic [DWS_LEN_W-1:0]   DWS_LEN_RESET  = 6'd3;
   localparam logic [DWS_GAIN_W-1:0]  DWS_GAIN_RESET = 16'd256;
   localparam int unsigned            DWS_LEN_MIN    = 2;

   // Register indexes
   typedef enum logic [DWS_CSR_IDX_W-1:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_GAIN          = 1'b1
   } dws_csr_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SUM,
      ST_MUL_LOAD,
      ST_MUL,
      ST_NUM,
      ST_DIV_CHECK,
      ST_DIV,
      ST_EMIT
   } dws_state_type;

   // Window store control
   typedef struct packed {
      logic write;
      logic drop;
   } dws_win_ctrl_type;

   // Serial datapath operations, at most one per cycle
   typedef struct packed {
      logic clear;
      logic sum_add;
      logic sum_sub;
      logic mul_load;
      logic mul_step;
      logic div_load;
      logic div_check;
      logic div_step;
   } dws_arith_op_type;

   // Bits that hold the half width for a given maximum window
   function automatic int unsigned dws_half_width(input int unsigned max_window);
      return $clog2((max_window >> 1) + 1);
   endfunction

   // Bits of one window sum
   function automatic int unsigned dws_sum_width(input int unsigned max_window);
      return DWS_PIXEL_W + dws_half_width(max_window);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/dws_window.sv */
`default_nettype none

// Pending pixels, oldest at entry 0
module dws_window import dws_pkg::*; #(
   parameter int unsigned MAX_WINDOW = DWS_MAX_WINDOW,
   localparam int unsigned IDX_W     = $clog2(MAX_WINDOW)
) (
   input  wire logic                   clock,
   input  wire dws_win_ctrl_type       ctrl,
   input  wire logic [IDX_W-1:0]       wr_idx,
   input  wire logic [DWS_PIXEL_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0]       rd_idx,
   output logic [DWS_PIXEL_W-1:0]      rd_data,
   output logic [DWS_PIXEL_W-1:0]      head
);

   logic [DWS_PIXEL_W-1:0] win_ff [MAX_WINDOW];

   // Append at the fill position, or shift the oldest out
   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         win_ff[wr_idx] <= wr_data;
      end else if (ctrl.drop) begin
         for (int i = 0; i < MAX_WINDOW - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[MAX_WINDOW-1] <= '0;
      end
   end

   assign rd_data = win_ff[rd_idx];
   assign head    = win_ff[0];

endmodule

`default_nettype wire

/* hw/rtl/dws_arith.sv */
`default_nettype none

// Serial datapath: window difference one tap per cycle, shift-add multiply
// one bit per cycle, restoring divide by the half width one quotient bit
// per cycle.
module dws_arith import dws_pkg::*; #(
   parameter int unsigned MAX_WINDOW = DWS_MAX_WINDOW,
   localparam int unsigned HALF_W    = dws_half_width(MAX_WINDOW)
) (
   input  wire logic                   clock,
   input  wire dws_arith_op_type       op,
   input  wire logic [DWS_PIXEL_W-1:0] rd_data,
   input  wire logic [DWS_PIXEL_W-1:0] head,
   input  wire logic [HALF_W-1:0]      half,
   input  wire logic [DWS_GAIN_W-1:0]  gain,
   output logic [DWS_PIXEL_W-1:0]      result
);

   localparam int unsigned SUM_W = dws_sum_width(MAX_WINDOW);
   localparam int unsigned NUM_W = SUM_W + DWS_GAIN_W + 1;
   localparam int unsigned M_W   = NUM_W - DWS_PIXEL_W - 1;
   localparam int unsigned GE_W  = DWS_GAIN_W + 1;

   logic signed [SUM_W:0]   diff_ff, diff_in;
   logic [SUM_W-1:0]        base_ff, base_in;
   logic [SUM_W-1:0]        mag_ff, mag_in;
   logic signed [GE_W-1:0]  geff_ff, geff_in;
   logic signed [NUM_W-1:0] prod_ff, prod_in;
   logic [M_W-1:0]          rem_ff, rem_in;
   logic [M_W-1:0]          dvs_ff, dvs_in;
   logic [DWS_QUO_W-1:0]    quo_ff, quo_in;
   logic                    zero_ff, zero_in;
   logic                    ovf_ff, ovf_in;

   logic signed [SUM_W:0]   rd_ext;
   logic signed [GE_W-1:0]  gain_ext;
   logic signed [NUM_W-1:0] addend;
   logic signed [NUM_W-1:0] base_ext;
   logic [M_W-1:0]          m_val;
   logic [M_W-1:0]          limit;

   assign rd_ext   = $signed({{(SUM_W-DWS_PIXEL_W+1){1'b0}}, rd_data});
   assign gain_ext = $signed({gain[DWS_GAIN_W-1], gain});
   assign addend   = mag_ff[SUM_W-1]
                     ? $signed({{(NUM_W-GE_W){geff_ff[GE_W-1]}}, geff_ff}) : '0;
   assign base_ext = $signed({{(NUM_W-SUM_W-DWS_PIXEL_W){1'b0}}, base_ff, 8'h00});
   assign m_val    = prod_ff[NUM_W-2:DWS_PIXEL_W];
   assign limit    = M_W'(half) << DWS_PIXEL_W;

   // Next values for each operation
   always_comb begin
      diff_in = diff_ff;
      base_in = base_ff;
      mag_in  = mag_ff;
      geff_in = geff_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      zero_in = zero_ff;
      ovf_in  = ovf_ff;
      if (op.clear) begin
         diff_in = '0;
         base_in = '0;
      end
      if (op.sum_add) begin
         // leading window; head pixel summed H times gives p0 * H
         diff_in = diff_ff + rd_ext;
         base_in = base_ff + SUM_W'(head);
      end
      if (op.sum_sub) begin
         diff_in = diff_ff - rd_ext;
      end
      if (op.mul_load) begin
         // sign of the difference is folded into the gain
         mag_in  = diff_ff[SUM_W] ? SUM_W'(-diff_ff) : SUM_W'(diff_ff);
         geff_in = diff_ff[SUM_W] ? -gain_ext : gain_ext;
         prod_in = '0;
      end
      if (op.mul_step) begin
         prod_in = (prod_ff <<< 1) + addend;
         mag_in  = mag_ff << 1;
      end
      if (op.div_load) begin
         prod_in = prod_ff + base_ext;
      end
      if (op.div_check) begin
         // numerator >> 8, then divide by H
         zero_in = prod_ff[NUM_W-1];
         ovf_in  = (m_val >= limit);
         rem_in  = m_val;
         dvs_in  = M_W'(half) << (DWS_QUO_W - 1);
         quo_in  = '0;
      end
      if (op.div_step) begin
         if (rem_ff >= dvs_ff) begin
            rem_in = rem_ff - dvs_ff;
            quo_in = {quo_ff[DWS_QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[DWS_QUO_W-2:0], 1'b0};
         end
         dvs_in = dvs_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      base_ff <= base_in;
      mag_ff  <= mag_in;
      geff_ff <= geff_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      zero_ff <= zero_in;
      ovf_ff  <= ovf_in;
   end

   // Clamp to pixel range
   always_comb begin
      if (zero_ff) begin
         result = '0;
      end else if (ovf_ff) begin
         result = DWS_PIXEL_MAX;
      end else begin
         result = quo_ff;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/differential_window_sharpen.sv */
// A filtered item's first released pixel passes ST_CHECK, ST_SUM, ST_MUL_LOAD, ST_MUL (SUM_W
// bits, 13 at MAX_WINDOW 32), ST_NUM, ST_DIV_CHECK, ST_DIV and ST_EMIT into the output register;
// a passed one only ST_CHECK and ST_EMIT. One window tap, one multiplier bit and one quotient
// bit per cycle. One item at a time; the next is taken in ST_IDLE once each pixel it releases
// is in the output register. Reset is synchronous: control, counters and output valid clear,
// window_length returns to 3 and gain to 256; pixel storage is not cleared.
`default_nettype none

module differential_window_sharpen import dws_pkg::*; #(
   parameter int unsigned MAX_WINDOW = DWS_MAX_WINDOW,
   parameter int unsigned MAX_LINE   = DWS_MAX_LINE
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [DWS_PIXEL_W-1:0]   req_pixel_in,
   input  wire logic                     req_last_in,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [DWS_PIXEL_W-1:0]        rsp_pixel_out,
   output logic                          rsp_last_out,
   input  wire logic                     csr_write_en,
   input  wire logic [DWS_CSR_IDX_W-1:0] csr_index,
   input  wire logic [DWS_CSR_DAT_W-1:0] csr_write_data
);

   localparam int unsigned IDX_W  = $clog2(MAX_WINDOW);
   localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int unsigned HALF_W = dws_half_width(MAX_WINDOW);
   localparam int unsigned SUM_W  = dws_sum_width(MAX_WINDOW);
   localparam int unsigned POS_W  = $clog2(MAX_LINE);
   localparam int unsigned STEP_W = $clog2(MAX_WINDOW + SUM_W + DWS_QUO_W);
   localparam int unsigned CMP_W  = POS_W + CNT_W;

   dws_state_type state_ff, state_in;

   logic [DWS_LEN_W-1:0]   length_ff, length_in;
   logic [DWS_GAIN_W-1:0]  gain_ff, gain_in;
   logic [CNT_W-1:0]       pending_ff, pending_in;
   logic [POS_W-1:0]       position_ff, position_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   last_ff, last_in;
   logic                   calc_ff, calc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DWS_PIXEL_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]       len;
   logic [CNT_W-1:0]       half;
   logic                   full;
   logic                   filt;
   logic                   out_free;
   logic                   sum_end;
   logic                   mul_end;
   logic                   div_end;
   logic                   step_lead;
   logic [STEP_W-1:0]      rd_sel;
   logic [IDX_W-1:0]       wr_idx;
   logic [IDX_W-1:0]       rd_idx;
   logic [DWS_PIXEL_W-1:0] rd_data;
   logic [DWS_PIXEL_W-1:0] head;
   logic [DWS_PIXEL_W-1:0] calc_pixel;
   logic                   accept;
   logic                   rsp_load;
   dws_win_ctrl_type       win_ctrl;
   dws_arith_op_type       arith_op;

   // Effective window length and half width
   always_comb begin
      if (int'(length_ff) < DWS_LEN_MIN) begin
         len = CNT_W'(DWS_LEN_MIN);
      end else if (int'(length_ff) > MAX_WINDOW) begin
         len = CNT_W'(MAX_WINDOW);
      end else begin
         len = CNT_W'(length_ff);
      end
      half = (len >> 1) - CNT_W'(1);
      if (half == '0) begin
         half = CNT_W'(1);
      end
   end

   assign full      = (pending_ff >= len);
   assign filt      = (CMP_W'(position_ff) >= CMP_W'(half));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_lead = (step_ff < STEP_W'(half));
   assign sum_end   = (step_ff == (STEP_W'(half) << 1) - STEP_W'(1));
   assign mul_end   = (step_ff == STEP_W'(SUM_W - 1));
   assign div_end   = (step_ff == STEP_W'(DWS_QUO_W - 1));

   // Leading window taps 0..H-1, then trailing taps L-H..L-1
   assign rd_sel = step_lead ? step_ff
                             : step_ff + STEP_W'(len) - (STEP_W'(half) << 1);
   assign rd_idx = rd_sel[IDX_W-1:0];
   assign wr_idx = (pending_ff >= CNT_W'(MAX_WINDOW)) ? IDX_W'(MAX_WINDOW - 1)
                                                      : pending_ff[IDX_W-1:0];

   // Configuration registers
   always_comb begin
      length_in = length_ff;
      gain_in   = gain_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: length_in = csr_write_data[DWS_LEN_W-1:0];
            CSR_GAIN:          gain_in   = csr_write_data[DWS_GAIN_W-1:0];
            default: begin
               length_in = length_ff;
               gain_in   = gain_ff;
            end
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (full) begin
               state_in = filt ? ST_SUM : ST_EMIT;
            end else if (last_ff && pending_ff != '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SUM: begin
            if (sum_end) begin
               state_in = ST_MUL_LOAD;
            end
         end
         ST_MUL_LOAD: state_in = ST_MUL;
         ST_MUL: begin
            if (mul_end) begin
               state_in = ST_NUM;
            end
         end
         ST_NUM:       state_in = ST_DIV_CHECK;
         ST_DIV_CHECK: state_in = ST_DIV;
         ST_DIV: begin
            if (div_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      rsp_load  = 1'b0;
      win_ctrl  = '0;
      arith_op  = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall      = 1'b0;
            accept         = req_valid;
            win_ctrl.write = req_valid;
         end
         ST_CHECK:     arith_op.clear     = 1'b1;
         ST_SUM: begin
            arith_op.sum_add = step_lead;
            arith_op.sum_sub = !step_lead;
         end
         ST_MUL_LOAD:  arith_op.mul_load  = 1'b1;
         ST_MUL:       arith_op.mul_step  = 1'b1;
         ST_NUM:       arith_op.div_load  = 1'b1;
         ST_DIV_CHECK: arith_op.div_check = 1'b1;
         ST_DIV:       arith_op.div_step  = 1'b1;
         ST_EMIT: begin
            rsp_load      = out_free;
            win_ctrl.drop = out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // Counters and run flags
   always_comb begin
      pending_in  = pending_ff;
      position_in = position_ff;
      last_in     = last_ff;
      calc_in     = calc_ff;
      step_in     = '0;
      if (accept) begin
         pending_in = CNT_W'(wr_idx) + CNT_W'(1);
         last_in    = req_last_in;
      end
      if (state_ff == ST_CHECK) begin
         calc_in = full && filt;
         if (!full && last_ff && pending_ff == '0) begin
            // end of run
            last_in     = 1'b0;
            position_in = '0;
         end
      end
      if ((state_ff == ST_SUM && !sum_end) || (state_ff == ST_MUL && !mul_end)
          || (state_ff == ST_DIV && !div_end)) begin
         step_in = step_ff + STEP_W'(1);
      end
      if (rsp_load) begin
         pending_in = pending_ff - CNT_W'(1);
         if (full && position_ff != POS_W'(MAX_LINE - 1)) begin
            position_in = position_ff + POS_W'(1);
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = calc_ff ? calc_pixel : head;
         rsp_last_in  = last_ff && !full && pending_ff == CNT_W'(1);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= DWS_LEN_RESET;
         gain_ff      <= DWS_GAIN_RESET;
         pending_ff   <= '0;
         position_ff  <= '0;
         step_ff      <= '0;
         last_ff      <= 1'b0;
         calc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         gain_ff      <= gain_in;
         pending_ff   <= pending_in;
         position_ff  <= position_in;
         step_ff      <= step_in;
         last_ff      <= last_in;
         calc_ff      <= calc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_last_out  = rsp_last_ff;

   dws_window #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_window (
      .clock   (clock),
      .ctrl    (win_ctrl),
      .wr_idx  (wr_idx),
      .wr_data (req_pixel_in),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .head    (head)
   );

   dws_arith #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_arith (
      .clock   (clock),
      .op      (arith_op),
      .rd_data (rd_data),
      .head    (head),
      .half    (half[HALF_W-1:0]),
      .gain    (gain_ff),
      .result  (calc_pixel)
   );

endmodule

`default_nettype wire

/* hw/rtl/dws_checker.sv */
`default_nettype none

module dws_checker import dws_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic [DWS_PIXEL_W-1:0]   rsp_pixel_out,
   input wire logic                     rsp_last_out
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
                                 && $stable(rsp_last_out))
      else $error("stalled result item changed");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One item in flight: input closes right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("input taken while previous item still in work");

   // A result does not rise in the cycle after the item arrives
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !$rose(rsp_valid))
      else $error("result released in the cycle after input accept");

endmodule

bind differential_window_sharpen dws_checker u_dws_checker (.*);

`default_nettype wire
